>>> rtl/oldq_pkg.sv
// Package for the ordered list deque: request codes, sequencer states, field widths.
package oldq_pkg;

  // Field widths of one request item and one result item
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 7;

  // Default list capacity
  localparam int unsigned OLDQ_DEPTH = 64;

  // Request codes
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_REAR  = 3'd1,
    FN_TAKE_FRONT = 3'd2,
    FN_TAKE_REAR  = 3'd3,
    FN_INSERT     = 3'd4,
    FN_DELETE     = 3'd5,
    FN_CLEAR      = 3'd6,
    FN_NONE       = 3'd7
  } func_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD_FRONT,
    ST_RD_REAR,
    ST_SH_RD,
    ST_SH_WR,
    ST_INS_WR,
    ST_FINISH
  } state_t;

endpackage

>>> rtl/oldq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module oldq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word and read one word; the read data is registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/ordered_list_deque.sv
// Ordered list deque: circular-buffer list in one RAM with positional insert and delete.
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------------
//   in      | in_valid/in_stall   | func, position, value
//   out     | out_valid/out_stall | front_value, rear_value, item_count, empty_flag,
//           |                     | full_flag, applied
//
// Pushes, refused requests, clear and none pass from the execute step straight to the
// result step; removing the first or last word adds one RAM read to fetch the new end
// word, unless it empties the list. A middle insert moves every word from the slot on, a
// middle delete every word behind the slot: each moved word costs one RAM read and one
// RAM write, and an insert then writes the new word. One item is in work at a time;
// in_stall is high until the sequencer returns to idle. Reset clears the count and the
// head pointer; RAM contents are not cleared. A held result under out_stall blocks the
// sequencer at its final step only.
module ordered_list_deque #(
  parameter int unsigned DEPTH = oldq_pkg::OLDQ_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [oldq_pkg::FUNC_W-1:0]          func,
  input  logic [oldq_pkg::POS_W-1:0]           position,
  input  logic signed [oldq_pkg::WORD_W-1:0]   value,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [oldq_pkg::WORD_W-1:0]   front_value,
  output logic signed [oldq_pkg::WORD_W-1:0]   rear_value,
  output logic [oldq_pkg::COUNT_W-1:0]         item_count,
  output logic                                 empty_flag,
  output logic                                 full_flag,
  output logic                                 applied
);

  import oldq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW:0]   DEPTH_S  = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  // Map a logical list index onto a RAM address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] lx);
    logic [CW:0] s;
    s = (CW + 1)'(hd) + (CW + 1)'(lx);
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[AW-1:0];
  endfunction

  state_t        state, state_next;
  func_t         req_func;
  logic [POS_W-1:0]  req_pos;
  logic [WORD_W-1:0] req_value;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] cur, cur_next;
  logic [CW-1:0] stop, stop_next;
  logic [CW-1:0] tgt, tgt_next;
  logic          dir_up, dir_up_next;
  logic [WORD_W-1:0] front, front_next;
  logic [WORD_W-1:0] rear, rear_next;
  logic          ok, ok_next;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;

  logic [XW-1:0] pos_x, cnt_x;
  logic [CW-1:0] ins_idx, del_idx;
  logic          del_ok, full, accept, load_out;
  logic          push_front_go, push_rear_go, ins_mid;
  logic          take_front_go, take_rear_go, del_mid;
  logic [CW+6:0] cnt_wide;

  oldq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign full     = (count == DEPTH_C);
  assign cnt_wide = (CW + 7)'(count);

  // Decode the target slot of an insert or delete
  always_comb begin
    pos_x = XW'(req_pos);
    cnt_x = XW'(count);
    if (count == '0 || req_pos <= POS_W'(1)) begin
      ins_idx = '0;
    end else if (pos_x - XW'(1) > cnt_x) begin
      ins_idx = count;
    end else begin
      ins_idx = CW'(pos_x - XW'(1));
    end
    del_ok  = (req_pos != '0) && (pos_x <= cnt_x);
    del_idx = CW'(pos_x - XW'(1));

    push_front_go = !full && ((req_func == FN_PUSH_FRONT) ||
                              (req_func == FN_INSERT && ins_idx == '0));
    push_rear_go  = !full && ((req_func == FN_PUSH_REAR) ||
                              (req_func == FN_INSERT && ins_idx != '0 && ins_idx == count));
    ins_mid       = !full && req_func == FN_INSERT && ins_idx != '0 && ins_idx != count;
    take_front_go = (req_func == FN_TAKE_FRONT && count != '0) ||
                    (req_func == FN_DELETE && del_ok && del_idx == '0);
    take_rear_go  = (req_func == FN_TAKE_REAR && count != '0) ||
                    (req_func == FN_DELETE && del_ok && del_idx != '0 &&
                     del_idx == count - CW'(1));
    del_mid       = req_func == FN_DELETE && del_ok && del_idx != '0 &&
                    del_idx != count - CW'(1);
  end

  // Next state, list bookkeeping and RAM control
  always_comb begin
    state_next  = state;
    head_next   = head;
    count_next  = count;
    cur_next    = cur;
    stop_next   = stop;
    tgt_next    = tgt;
    dir_up_next = dir_up;
    front_next  = front;
    rear_next   = rear;
    ok_next     = ok;
    wr_en       = 1'b0;
    wr_addr     = phys(head, cur);
    wr_data     = req_value;
    rd_addr     = phys(head, dir_up ? cur + CW'(1) : cur - CW'(1));
    load_out    = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        ok_next    = 1'b1;
        state_next = ST_FINISH;
        priority if (push_front_go) begin
          head_next  = (head == '0) ? LAST_PTR : head - AW'(1);
          wr_en      = 1'b1;
          wr_addr    = (head == '0) ? LAST_PTR : head - AW'(1);
          count_next = count + CW'(1);
          front_next = req_value;
          if (count == '0) begin
            rear_next = req_value;
          end
        end else if (push_rear_go) begin
          wr_en      = 1'b1;
          wr_addr    = phys(head, count);
          count_next = count + CW'(1);
          rear_next  = req_value;
          if (count == '0) begin
            front_next = req_value;
          end
        end else if (ins_mid) begin
          cur_next    = count;
          stop_next   = ins_idx + CW'(1);
          tgt_next    = ins_idx;
          dir_up_next = 1'b0;
          state_next  = ST_SH_RD;
        end else if (take_front_go) begin
          rd_addr    = phys(head, CW'(1));
          head_next  = (head == LAST_PTR) ? '0 : head + AW'(1);
          count_next = count - CW'(1);
          if (count > CW'(1)) begin
            state_next = ST_RD_FRONT;
          end
        end else if (take_rear_go) begin
          rd_addr    = phys(head, count - CW'(2));
          count_next = count - CW'(1);
          if (count > CW'(1)) begin
            state_next = ST_RD_REAR;
          end
        end else if (del_mid) begin
          cur_next    = del_idx;
          stop_next   = count - CW'(2);
          dir_up_next = 1'b1;
          state_next  = ST_SH_RD;
        end else if (req_func == FN_CLEAR) begin
          count_next = '0;
        end else if (req_func == FN_NONE) begin
          ok_next = 1'b1;
        end else begin
          ok_next = 1'b0;
        end
      end

      ST_RD_FRONT: begin
        front_next = rd_data;
        state_next = ST_FINISH;
      end

      ST_RD_REAR: begin
        rear_next  = rd_data;
        state_next = ST_FINISH;
      end

      // Fetch the neighbor that moves into the current slot
      ST_SH_RD: begin
        state_next = ST_SH_WR;
      end

      // Write the moved word, then step or finish the shift
      ST_SH_WR: begin
        wr_en   = 1'b1;
        wr_addr = phys(head, cur);
        wr_data = rd_data;
        if (cur == stop) begin
          if (dir_up) begin
            count_next = count - CW'(1);
            state_next = ST_FINISH;
          end else begin
            state_next = ST_INS_WR;
          end
        end else begin
          cur_next   = dir_up ? cur + CW'(1) : cur - CW'(1);
          state_next = ST_SH_RD;
        end
      end

      ST_INS_WR: begin
        wr_en      = 1'b1;
        wr_addr    = phys(head, tgt);
        count_next = count + CW'(1);
        state_next = ST_FINISH;
      end

      ST_FINISH: begin
        if (!(out_valid && out_stall)) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture, work registers and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      req_func  <= func_t'(func);
      req_pos   <= position;
      req_value <= value;
    end
    cur    <= cur_next;
    stop   <= stop_next;
    tgt    <= tgt_next;
    dir_up <= dir_up_next;
    front  <= front_next;
    rear   <= rear_next;
    ok     <= ok_next;
    if (load_out) begin
      front_value <= (count != '0) ? front : '0;
      rear_value  <= (count != '0) ? rear : '0;
      item_count  <= cnt_wide[COUNT_W-1:0];
      empty_flag  <= (count == '0);
      full_flag   <= full;
      applied     <= ok;
    end
  end

endmodule
